[hdl/sha1md_pkg.sv]
`default_nettype none

package sha1md_pkg;

  localparam int unsigned ROUNDS     = 80;
  localparam int unsigned BLK_WORDS  = 16;
  localparam int unsigned CHAIN_WORDS = 5;
  localparam int unsigned DIGEST_BYTES = 20;
  localparam int unsigned COUNT_W    = 61;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] ROUND_K [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  localparam logic [31:0] H_INIT [CHAIN_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_t;

  typedef struct packed {
    logic [7:0] digest_byte;
    logic       digest_last;
  } out_t;

  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_PAD,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic       shift_en;
    byte_sel_t  byte_sel;
    logic [2:0] len_idx;
    logic       count_inc;
    logic       load_vars;
    logic       round_en;
    logic       add_chain;
    logic       digest_shift;
    logic       clear;
  } cmd_t;

  typedef struct packed {
    logic pos_last;
    logic pos_pad;
    logic round_last;
  } stat_t;

endpackage

`default_nettype wire

[hdl/sha1md_dp.sv]
`default_nettype none

module sha1md_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sha1md_pkg::cmd_t  cmd,
  input  wire logic [7:0]        data_byte,
  output sha1md_pkg::stat_t      stat,
  output logic [7:0]             digest_byte
);

  localparam logic [5:0] POS_LAST = 6'd63;
  localparam logic [5:0] POS_PAD  = 6'd56;
  localparam logic [6:0] RND_LAST = 7'(sha1md_pkg::ROUNDS - 1);

  logic [31:0] blk_r   [sha1md_pkg::BLK_WORDS];
  logic [31:0] blk_nxt [sha1md_pkg::BLK_WORDS];
  logic [31:0] chain_r   [sha1md_pkg::CHAIN_WORDS];
  logic [31:0] chain_nxt [sha1md_pkg::CHAIN_WORDS];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [5:0]  pos_r;
  logic [sha1md_pkg::COUNT_W-1:0] count_r;
  logic [6:0]  rnd_r;

  logic [63:0] len_bits;
  logic [7:0]  in_byte;
  logic [31:0] sched_new;
  logic [1:0]  q;
  logic [31:0] f;
  logic [31:0] tmp;

  assign len_bits = {count_r, 3'b000};

  always_comb begin
    case (cmd.byte_sel)
      sha1md_pkg::SEL_DATA: in_byte = data_byte;
      sha1md_pkg::SEL_PAD:  in_byte = sha1md_pkg::PAD_BYTE;
      sha1md_pkg::SEL_ZERO: in_byte = 8'h00;
      sha1md_pkg::SEL_LEN:  in_byte = len_bits[{~cmd.len_idx, 3'b000} +: 8];
      default:              in_byte = 8'h00;
    endcase
  end

  // blk_r[i] holds schedule word t+i during the rounds
  assign sched_new = blk_r[13] ^ blk_r[8] ^ blk_r[2] ^ blk_r[0];

  always_comb begin
    if (rnd_r < 7'd20) begin
      q = 2'd0;
    end else if (rnd_r < 7'd40) begin
      q = 2'd1;
    end else if (rnd_r < 7'd60) begin
      q = 2'd2;
    end else begin
      q = 2'd3;
    end
  end

  always_comb begin
    case (q)
      2'd0:    f = (b_r & c_r) | (~b_r & d_r);
      2'd2:    f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      default: f = b_r ^ c_r ^ d_r;
    endcase
  end

  assign tmp = {a_r[26:0], a_r[31:27]} + f + e_r + blk_r[0] + sha1md_pkg::ROUND_K[q];

  always_comb begin
    for (int i = 0; i < sha1md_pkg::BLK_WORDS; i++) begin
      blk_nxt[i] = blk_r[i];
    end
    if (cmd.shift_en) begin
      for (int i = 0; i < sha1md_pkg::BLK_WORDS - 1; i++) begin
        blk_nxt[i] = {blk_r[i][23:0], blk_r[i+1][31:24]};
      end
      blk_nxt[sha1md_pkg::BLK_WORDS-1] = {blk_r[sha1md_pkg::BLK_WORDS-1][23:0], in_byte};
    end else if (cmd.round_en) begin
      for (int i = 0; i < sha1md_pkg::BLK_WORDS - 1; i++) begin
        blk_nxt[i] = blk_r[i+1];
      end
      blk_nxt[sha1md_pkg::BLK_WORDS-1] = {sched_new[30:0], sched_new[31]};
    end
  end

  always_comb begin
    for (int i = 0; i < sha1md_pkg::CHAIN_WORDS; i++) begin
      chain_nxt[i] = chain_r[i];
    end
    if (cmd.clear) begin
      for (int i = 0; i < sha1md_pkg::CHAIN_WORDS; i++) begin
        chain_nxt[i] = sha1md_pkg::H_INIT[i];
      end
    end else if (cmd.add_chain) begin
      chain_nxt[0] = chain_r[0] + a_r;
      chain_nxt[1] = chain_r[1] + b_r;
      chain_nxt[2] = chain_r[2] + c_r;
      chain_nxt[3] = chain_r[3] + d_r;
      chain_nxt[4] = chain_r[4] + e_r;
    end else if (cmd.digest_shift) begin
      // whole chaining value moves up one byte per output transfer
      for (int i = 0; i < sha1md_pkg::CHAIN_WORDS - 1; i++) begin
        chain_nxt[i] = {chain_r[i][23:0], chain_r[i+1][31:24]};
      end
      chain_nxt[sha1md_pkg::CHAIN_WORDS-1] = {chain_r[sha1md_pkg::CHAIN_WORDS-1][23:0], 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < sha1md_pkg::BLK_WORDS; i++) begin
      blk_r[i] <= blk_nxt[i];
    end
    if (cmd.load_vars) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (cmd.round_en) begin
      e_r <= d_r;
      d_r <= c_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      b_r <= a_r;
      a_r <= tmp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sha1md_pkg::CHAIN_WORDS; i++) begin
        chain_r[i] <= sha1md_pkg::H_INIT[i];
      end
      pos_r   <= '0;
      count_r <= '0;
      rnd_r   <= '0;
    end else begin
      for (int i = 0; i < sha1md_pkg::CHAIN_WORDS; i++) begin
        chain_r[i] <= chain_nxt[i];
      end
      if (cmd.clear) begin
        pos_r   <= '0;
        count_r <= '0;
      end else begin
        if (cmd.shift_en) begin
          pos_r <= pos_r + 6'd1;
        end
        if (cmd.count_inc) begin
          count_r <= count_r + {{(sha1md_pkg::COUNT_W-1){1'b0}}, 1'b1};
        end
      end
      if (cmd.load_vars) begin
        rnd_r <= '0;
      end else if (cmd.round_en) begin
        rnd_r <= (rnd_r == RND_LAST) ? 7'd0 : rnd_r + 7'd1;
      end
    end
  end

  assign stat.pos_last   = (pos_r == POS_LAST);
  assign stat.pos_pad    = (pos_r == POS_PAD);
  assign stat.round_last = (rnd_r == RND_LAST);

  assign digest_byte = chain_r[0][31:24];

endmodule

`default_nettype wire

[hdl/sha1md_ctrl.sv]
`default_nettype none

module sha1md_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               has_byte,
  input  wire logic               end_of_message,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    digest_last,
  input  wire sha1md_pkg::stat_t  stat,
  output sha1md_pkg::cmd_t        cmd
);

  localparam logic [4:0] OUT_LAST = 5'(sha1md_pkg::DIGEST_BYTES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD80,
    S_PADZ,
    S_PADLEN,
    S_LOAD,
    S_ROUND,
    S_ADD,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    RET_IDLE,
    RET_PAD80,
    RET_PADZ,
    RET_OUT
  } ret_t;

  state_t     state_r, state_nxt;
  ret_t       ret_r, ret_nxt;
  logic [2:0] len_idx_r, len_idx_nxt;
  logic [4:0] out_idx_r, out_idx_nxt;

  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    len_idx_nxt = len_idx_r;
    out_idx_nxt = out_idx_r;
    cmd         = '0;
    cmd.byte_sel = sha1md_pkg::SEL_DATA;
    cmd.len_idx  = len_idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (has_byte) begin
            cmd.shift_en  = 1'b1;
            cmd.count_inc = 1'b1;
          end
          if (has_byte && stat.pos_last) begin
            state_nxt = S_LOAD;
            ret_nxt   = end_of_message ? RET_PAD80 : RET_IDLE;
          end else if (end_of_message) begin
            state_nxt = S_PAD80;
          end
        end
      end
      S_PAD80: begin
        cmd.shift_en = 1'b1;
        cmd.byte_sel = sha1md_pkg::SEL_PAD;
        if (stat.pos_last) begin
          state_nxt = S_LOAD;
          ret_nxt   = RET_PADZ;
        end else begin
          state_nxt = S_PADZ;
        end
      end
      S_PADZ: begin
        if (stat.pos_pad) begin
          state_nxt   = S_PADLEN;
          len_idx_nxt = '0;
        end else begin
          cmd.shift_en = 1'b1;
          cmd.byte_sel = sha1md_pkg::SEL_ZERO;
          if (stat.pos_last) begin
            state_nxt = S_LOAD;
            ret_nxt   = RET_PADZ;
          end
        end
      end
      S_PADLEN: begin
        cmd.shift_en = 1'b1;
        cmd.byte_sel = sha1md_pkg::SEL_LEN;
        len_idx_nxt  = len_idx_r + 3'd1;
        if (len_idx_r == 3'd7) begin
          state_nxt = S_LOAD;
          ret_nxt   = RET_OUT;
        end
      end
      S_LOAD: begin
        cmd.load_vars = 1'b1;
        state_nxt     = S_ROUND;
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        if (stat.round_last) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add_chain = 1'b1;
        case (ret_r)
          RET_IDLE:  state_nxt = S_IDLE;
          RET_PAD80: state_nxt = S_PAD80;
          RET_PADZ:  state_nxt = S_PADZ;
          RET_OUT:   state_nxt = S_OUT;
          default:   state_nxt = S_IDLE;
        endcase
        out_idx_nxt = '0;
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.digest_shift = 1'b1;
          out_idx_nxt      = out_idx_r + 5'd1;
          if (out_idx_r == OUT_LAST) begin
            // digest done, start over for the next message
            cmd.clear   = 1'b1;
            out_idx_nxt = '0;
            state_nxt   = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ret_r     <= RET_IDLE;
      len_idx_r <= '0;
      out_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      ret_r     <= ret_nxt;
      len_idx_r <= len_idx_nxt;
      out_idx_r <= out_idx_nxt;
    end
  end

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = (state_r == S_OUT);
  assign digest_last = (out_idx_r == OUT_LAST);

endmodule

`default_nettype wire

[hdl/sha1_message_digest_core.sv]
`default_nettype none

// sha-1 digest core, one message byte per input transfer
// input: a message byte is taken while in_ready is high; a full 64-byte block is then
//   compressed (load, 80 rounds of the single round unit, chain add) with input held off
// end of message: padding and length bytes are shifted in with one or two compressions,
//   then 20 digest bytes at up to one per cycle while out_ready is high
// reset: synchronous, active low; chaining value back to initial constants, counters cleared
module sha1_message_digest_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sha1md_pkg::in_t   in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sha1md_pkg::out_t       out_data
);

  sha1md_pkg::cmd_t  cmd;
  sha1md_pkg::stat_t stat;
  logic              digest_last;
  logic [7:0]        digest_byte;

  sha1md_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .has_byte       (in_data.has_byte),
    .end_of_message (in_data.end_of_message),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .digest_last    (digest_last),
    .stat           (stat),
    .cmd            (cmd)
  );

  sha1md_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_data.data_byte),
    .stat        (stat),
    .digest_byte (digest_byte)
  );

  assign out_data.digest_byte = digest_byte;
  assign out_data.digest_last = digest_last;

endmodule

`default_nettype wire

[dv/sha1_message_digest_core_tb.sv]
`timescale 1ns / 100ps

module sha1_message_digest_core_tb;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned FLUSH_CYCLES = 400;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [31:0] K_TAB [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };
  localparam logic [31:0] IV [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  sha1md_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sha1md_pkg::out_t out_data;

  // shadow of the hash state
  logic [31:0] chain_h [5];
  logic [31:0] blk_w [16];
  logic [60:0] msg_len;
  sha1md_pkg::out_t digest_q [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int unsigned noise_sent = 0;
  int unsigned messages_closed = 0;
  int unsigned digest_bytes_checked = 0;
  int unsigned quiet_cycles = 0;

  sha1_message_digest_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("%0t ERROR %s", $time, what);
  endtask

  function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void restart_digest();
    for (int i = 0; i < 5; i++) chain_h[i] = IV[i];
    for (int i = 0; i < 16; i++) blk_w[i] = '0;
    msg_len = '0;
  endfunction

  function automatic void put_msg_byte(input int unsigned pos, input logic [7:0] b);
    if ((pos % 4) == 0) blk_w[pos / 4] = '0;
    blk_w[pos / 4][8 * (3 - pos % 4) +: 8] = b;
  endfunction

  function automatic void compress_block();
    logic [31:0] sched [16];
    logic [31:0] a, b, c, d, e, f, w, t;
    int unsigned q;
    sched = blk_w;
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      q = r / 20;
      if (r < 16) begin
        w = sched[r];
      end else begin
        w = rol(sched[(r - 3) % 16] ^ sched[(r - 8) % 16] ^ sched[(r - 14) % 16] ^
                sched[r % 16], 1);
        sched[r % 16] = w;
      end
      case (q)
        0: f = (b & c) | (~b & d);
        2: f = (b & c) | (b & d) | (c & d);
        default: f = b ^ c ^ d;
      endcase
      t = rol(a, 5) + f + e + w + K_TAB[q];
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  // pad, append the bit length, queue the 20 digest bytes, start afresh
  function automatic void close_message();
    int unsigned pos;
    logic [63:0] bit_len;
    sha1md_pkg::out_t res;
    pos = 32'(msg_len[5:0]);
    put_msg_byte(pos, PAD_MARK);
    pos++;
    if (pos == 64) begin
      compress_block();
      pos = 0;
    end
    while (pos != 56) begin
      put_msg_byte(pos, 8'h00);
      pos++;
      if (pos == 64) begin
        compress_block();
        pos = 0;
      end
    end
    bit_len = {msg_len, 3'b000};
    for (int i = 0; i < 8; i++) put_msg_byte(56 + i, bit_len[63 - 8 * i -: 8]);
    compress_block();
    for (int i = 0; i < 20; i++) begin
      res.digest_byte = chain_h[i / 4][8 * (3 - i % 4) +: 8];
      res.digest_last = (i == 19);
      digest_q.push_back(res);
    end
    restart_digest();
  endfunction

  function automatic void absorb_transfer(input sha1md_pkg::in_t item);
    if (item.has_byte || item.end_of_message) items_sent++;
    else noise_sent++;
    if (item.has_byte) begin
      put_msg_byte(32'(msg_len[5:0]), item.data_byte);
      msg_len = msg_len + 1'b1;
      if (msg_len[5:0] == 6'd0) compress_block();
    end
    if (item.end_of_message) begin
      messages_closed++;
      close_message();
    end
  endfunction

  // handshakes are sampled at the falling edge, where everything is settled
  task automatic send_item(input sha1md_pkg::in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    absorb_transfer(item);
    @(posedge clk);
  endtask

  task automatic send_fields(input logic [7:0] data, input logic has, input logic eom);
    sha1md_pkg::in_t item;
    item.data_byte = data;
    item.has_byte = has;
    item.end_of_message = eom;
    send_item(item);
  endtask

  // close either on the last byte or with a separate empty closing transfer
  task automatic send_message(input int unsigned len, input bit close_on_byte,
                              input int unsigned noise_pct);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(99) < noise_pct) send_fields(8'($urandom_range(255)), 1'b0, 1'b0);
      send_fields(8'($urandom_range(255)), 1'b1, close_on_byte && (i == len - 1));
    end
    if (!close_on_byte || len == 0) send_fields(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic wait_for_digests();
    in_valid <= 1'b0;
    do @(posedge clk); while (digest_q.size() != 0);
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // empty message, then an ignored transfer ahead of another empty one
    send_fields(8'h00, 1'b0, 1'b1);
    send_fields(8'hFF, 1'b0, 1'b0);
    send_fields(8'hFF, 1'b0, 1'b1);
    send_fields(8'h61, 1'b1, 1'b0);
    send_fields(8'h62, 1'b1, 1'b0);
    send_fields(8'h63, 1'b1, 1'b1);
    send_fields(8'h00, 1'b1, 1'b1);
    send_fields(8'hFF, 1'b1, 1'b1);
    // data on the closing transfer must be ignored
    send_fields(8'hAA, 1'b1, 1'b0);
    send_fields(8'h55, 1'b1, 1'b0);
    send_fields(8'h80, 1'b0, 1'b1);
    send_fields(8'h01, 1'b1, 1'b0);
    send_fields(8'h7F, 1'b0, 1'b0);
    send_fields(8'hFE, 1'b1, 1'b1);
    wait_for_digests();
  endtask

  // lengths where the pad just fits, spills into a second block or lands on the last byte
  task automatic test_pad_boundaries();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_message(55, 1'b1, 0);
    send_message(56, 1'b0, 0);
    send_message(63, 1'b1, 0);
    send_message(64, 1'b0, 0);
    wait_for_digests();
  endtask

  task automatic test_random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                                   input int unsigned n_items);
    int unsigned stop_at;
    int unsigned len;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(4) == 0) begin
        case ($urandom_range(3))
          0: len = 55;
          1: len = 56;
          2: len = 63;
          default: len = $urandom_range(128, 65);
        endcase
      end else begin
        len = $urandom_range(40);
      end
      send_message(len, 1'($urandom_range(1)), ($urandom_range(3) == 0) ? 10 : 0);
      if ($urandom_range(5) == 0) wait_for_digests();
    end
    wait_for_digests();
  endtask

  always @(negedge clk) begin
    sha1md_pkg::out_t exp_b;
    if (rst_n && out_valid && out_ready) begin
      digest_bytes_checked++;
      if (digest_q.size() == 0) begin
        report_mismatch($sformatf("unexpected digest byte %02h", out_data.digest_byte));
      end else begin
        exp_b = digest_q.pop_front();
        if (out_data.digest_byte !== exp_b.digest_byte)
          report_mismatch($sformatf("digest_byte %02h, want %02h",
                                    out_data.digest_byte, exp_b.digest_byte));
        if (out_data.digest_last !== exp_b.digest_last)
          report_mismatch($sformatf("digest_last %0b, want %0b",
                                    out_data.digest_last, exp_b.digest_last));
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("sha1_message_digest_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    restart_digest();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_pad_boundaries();
    test_random_phase(86, 0, 40);
    test_random_phase(0, 86, 40);
    test_random_phase(11, 11, 40);
    test_random_phase(0, 0, 40);
    repeat (FLUSH_CYCLES) @(posedge clk);
    $display("run: %0d message transfers, %0d ignored, %0d messages, %0d digest bytes",
             items_sent, noise_sent, messages_closed, digest_bytes_checked);
    $display("run: pad boundaries 55/56/63/64, multi-block, idle and stall mixes");
    if (fail_count == 0) begin
      $display("sha1_message_digest_core: match");
    end else begin
      $display("sha1_message_digest_core: mismatch");
    end
    $finish;
  end

endmodule

[sha1_message_digest_core.f]
hdl/sha1md_pkg.sv
hdl/sha1md_dp.sv
hdl/sha1md_ctrl.sv
hdl/sha1_message_digest_core.sv
dv/sha1_message_digest_core_tb.sv
